### design/assert_macros.svh
// Assertion macros shared by the calibration block.
// Depends on clk_i and rst_ni being present in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed in calibration block");
// Condition that must never be true on a clock edge outside reset.
`define ASSERT_NEVER(lbl, expr) \
  `ASSERT_CLK(lbl, !(expr))
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, expr)
`endif
`endif

### design/tplc_pkg.sv
// Shared types and constants of the two-point light calibration block.
// No dependencies; used by tplc_ctrl and the top level.
package tplc_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int GAP_BITS        = 12;

  localparam logic [GAP_BITS-1:0] RESET_MIN_GAP = 12'd300;
  localparam int RESET_DARK_TRIP  = 1500;
  localparam int RESET_LIGHT_TRIP = 2500;

  localparam logic [2:0] BLINK_NONE     = 3'd0;
  localparam logic [2:0] BLINK_STARTED  = 3'd3;
  localparam logic [2:0] BLINK_ABORTED  = 3'd1;
  localparam logic [2:0] BLINK_DARK     = 3'd1;
  localparam logic [2:0] BLINK_REJECTED = 3'd5;
  localparam logic [2:0] BLINK_ACCEPTED = 3'd3;

  typedef enum logic [1:0] {
    MODE_NORMAL      = 2'd0,
    MODE_AWAIT_DARK  = 2'd1,
    MODE_AWAIT_LIGHT = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    EV_IGNORED  = 3'd0,
    EV_STARTED  = 3'd1,
    EV_ABORTED  = 3'd2,
    EV_DARK     = 3'd3,
    EV_REJECTED = 3'd4,
    EV_ACCEPTED = 3'd5
  } event_e;

  // Control and status part of one result.
  typedef struct packed {
    mode_e      mode;
    event_e     ev;
    logic       key_on;
    logic [2:0] blinks;
    logic       save;
  } ctrl_t;

endpackage

### design/two_point_light_calibration.sv
// Two-point light calibration: input register, decision logic, result register.
// A request passes from the input register through the decision logic into the result register.
// Throughput: one request per cycle while the result side does not stall, set by the single decision stage.
// The input side keeps accepting while a result waits, as long as the result register drains.
// Reset clears both registers' valid flags, the mode, and loads trip points 1500/2500, gap 300.
// Depends on tplc_pkg, tplc_ctrl, tplc_div3 and assert_macros.svh.
`include "assert_macros.svh"
module two_point_light_calibration import tplc_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_FIELD_W = 10 + 4 * SAMPLE_BITS,
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration: min_gap
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [GAP_BITS-1:0]    cfg_data_i,
  // Request side
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // light_sample, zero fill
  input  logic                   s_axis_tuser,  // req_type
  // Result side
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata   // mode_after, event_code, key_on,
                                                // blink_count, save_request, saved_dark,
                                                // saved_light, dark_trip_now,
                                                // light_trip_now, zero fill
);

  localparam int SB = SAMPLE_BITS;

  logic                   in_valid_q;
  logic                   in_long_q;
  logic [SB-1:0]          in_sample_q;
  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;
  logic [GAP_BITS-1:0]    min_gap_q;
  logic                   advance;
  ctrl_t                  ctrl;
  logic [SB-1:0]          saved_dark, saved_light, dark_trip, light_trip;

  // A request moves on when the result register is free or being drained.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_gap_q <= RESET_MIN_GAP;
    end else if (cfg_valid_i) begin
      min_gap_q <= cfg_data_i;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_long_q   <= s_axis_tuser;
      in_sample_q <= s_axis_tdata[SB-1:0];
    end
  end

  tplc_ctrl #(.SAMPLE_BITS(SB)) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .is_long_i     (in_long_q),
    .sample_i      (in_sample_q),
    .min_gap_i     (min_gap_q),
    .ctrl_o        (ctrl),
    .saved_dark_o  (saved_dark),
    .saved_light_o (saved_light),
    .dark_trip_o   (dark_trip),
    .light_trip_o  (light_trip)
  );

  // Pack the result, first field in the lowest bits.
  assign out_data_d = OUT_TDATA_W'({light_trip, dark_trip, saved_light, saved_dark,
                                    ctrl.save, ctrl.blinks, ctrl.key_on, ctrl.ev,
                                    ctrl.mode});

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  // A waiting result is never overwritten.
  `ASSERT_NEVER(a_no_overwrite, advance && out_valid_q && !m_axis_tready)
  // A save request comes only with an accepted pair.
  `ASSERT_CLK(a_save_accept, advance |-> (ctrl.save == (ctrl.ev == EV_ACCEPTED)))
  // A started calibration always waits for the dark sample next.
  `ASSERT_CLK(a_start_mode, (advance && ctrl.ev == EV_STARTED) |-> (ctrl.mode == MODE_AWAIT_DARK))

endmodule

### design/tplc_div3.sv
// Divide-by-three of an unsigned value by multiplying with a reciprocal.
// Depends on nothing; used by tplc_ctrl.
module tplc_div3 #(
  parameter int W = 12
) (
  input  logic [W-1:0] x_i,
  output logic [W-1:0] q_o
);

  // With K = W + 1 the reciprocal error stays below one unit for every x.
  localparam int K = W + 1;
  localparam logic [K-1:0] RECIP = K'((2 ** K) / 3 + 1);

  logic [W+K-1:0] prod;

  // Quotient is the upper part of the product.
  assign prod = (W+K)'(x_i) * (W+K)'(RECIP);
  assign q_o  = prod[W+K-1:K];

endmodule

### design/tplc_ctrl.sv
// Calibration state and the decision for one button request.
// Depends on tplc_pkg and tplc_div3.
module tplc_ctrl import tplc_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic                   is_long_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic [GAP_BITS-1:0]    min_gap_i,
  output ctrl_t                  ctrl_o,
  output logic [SAMPLE_BITS-1:0] saved_dark_o,
  output logic [SAMPLE_BITS-1:0] saved_light_o,
  output logic [SAMPLE_BITS-1:0] dark_trip_o,
  output logic [SAMPLE_BITS-1:0] light_trip_o
);

  localparam int SB = SAMPLE_BITS;
  localparam int CW = ((SB > GAP_BITS) ? SB : GAP_BITS) + 2;

  mode_e           mode_q, mode_d;
  logic [SB-1:0]   held_q, held_d;
  logic [SB-1:0]   dtrip_q, dtrip_d;
  logic [SB-1:0]   ltrip_q, ltrip_d;

  logic signed [SB:0]   diff;
  logic signed [CW-1:0] diff_w;
  logic signed [CW-1:0] gap_w;
  logic                 gap_ok;
  logic [SB-1:0]        span;
  logic [SB:0]          span2;
  logic [SB-1:0]        third;
  logic [SB:0]          two_third;

  // Signed difference against the held dark sample, checked against the gap.
  assign diff   = $signed({1'b0, sample_i}) - $signed({1'b0, held_q});
  assign diff_w = CW'(diff);
  assign gap_w  = signed'({{(CW-GAP_BITS){1'b0}}, min_gap_i});
  assign gap_ok = (diff_w >= gap_w);
  assign span   = diff[SB-1:0];
  assign span2  = {span, 1'b0};

  tplc_div3 #(.W(SB)) u_div_one (
    .x_i (span),
    .q_o (third)
  );

  tplc_div3 #(.W(SB+1)) u_div_two (
    .x_i (span2),
    .q_o (two_third)
  );

  // Next state and result for the request in the input register.
  always_comb begin
    mode_d        = MODE_NORMAL;
    held_d        = held_q;
    dtrip_d       = dtrip_q;
    ltrip_d       = ltrip_q;
    ctrl_o.ev     = EV_IGNORED;
    ctrl_o.key_on = 1'b0;
    ctrl_o.blinks = BLINK_NONE;
    ctrl_o.save   = 1'b0;
    saved_dark_o  = '0;
    saved_light_o = '0;
    if (is_long_i) begin
      if (mode_q == MODE_AWAIT_DARK || mode_q == MODE_AWAIT_LIGHT) begin
        ctrl_o.ev     = EV_ABORTED;
        ctrl_o.blinks = BLINK_ABORTED;
      end else begin
        ctrl_o.ev     = EV_STARTED;
        ctrl_o.blinks = BLINK_STARTED;
        ctrl_o.key_on = 1'b1;
        mode_d        = MODE_AWAIT_DARK;
      end
    end else begin
      unique case (mode_q)
        MODE_AWAIT_DARK: begin
          held_d        = sample_i;
          ctrl_o.ev     = EV_DARK;
          ctrl_o.blinks = BLINK_DARK;
          mode_d        = MODE_AWAIT_LIGHT;
        end
        MODE_AWAIT_LIGHT: begin
          if (gap_ok) begin
            dtrip_d       = held_q + third;
            ltrip_d       = held_q + two_third[SB-1:0];
            ctrl_o.ev     = EV_ACCEPTED;
            ctrl_o.blinks = BLINK_ACCEPTED;
            ctrl_o.save   = 1'b1;
            saved_dark_o  = held_q;
            saved_light_o = sample_i;
          end else begin
            ctrl_o.ev     = EV_REJECTED;
            ctrl_o.blinks = BLINK_REJECTED;
          end
        end
        default: begin
          ctrl_o.ev = EV_IGNORED;
        end
      endcase
    end
    ctrl_o.mode  = mode_d;
    dark_trip_o  = dtrip_d;
    light_trip_o = ltrip_d;
  end

  // State advances once per request that moves to the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_NORMAL;
      held_q  <= '0;
      dtrip_q <= SB'(RESET_DARK_TRIP);
      ltrip_q <= SB'(RESET_LIGHT_TRIP);
    end else if (step_i) begin
      mode_q  <= mode_d;
      held_q  <= held_d;
      dtrip_q <= dtrip_d;
      ltrip_q <= ltrip_d;
    end
  end

endmodule
